>>> hdl/idw_pkg.sv
// Shared widths, constants and types for the inverse distance weighting block.
`default_nettype none
package idw_pkg;
    localparam int W_FRAC  = 16;             // weight fraction bits (Q1.16)
    localparam int DIST_W  = 24;             // signed distance width
    localparam int DMAG_W  = DIST_W - 1;     // clamped magnitude width
    localparam int Q_W     = W_FRAC + 2;     // ratio quotient, below 4.0
    localparam int Q2_W    = 2 * Q_W - W_FRAC;
    localparam int R_W     = 2 * Q2_W - W_FRAC;
    localparam int SUM_W   = R_W + 2;
    localparam int WGT_W   = W_FRAC + 1;
    localparam int SUM2_W  = WGT_W + 2;
    localparam int IN_TDATA_W  = 4 * DIST_W;
    localparam int OUT_TDATA_W = ((4 * WGT_W + 7) / 8) * 8;

    localparam logic [R_W-1:0]   RATIO_MAX    = {R_W{1'b1}};
    localparam logic [WGT_W-1:0] ONE_W        = WGT_W'(1) << W_FRAC;
    localparam logic [WGT_W-1:0] THRESH_RESET = WGT_W'(655);

    typedef struct packed {
        logic zero;   // divisor distance is zero
        logic sat;    // ratio at or above 4.0
    } ratio_flags_t;
endpackage
`default_nettype wire

>>> hdl/inverse_distance_weight_four.sv
// Top level: four-lane inverse distance weighting with threshold and renormalization.
`default_nettype none
// Turns four signed Q12.12 distances into four Q1.16 weights. Negative distances
// count as zero. Each lane forms (d0/di)^4, zero where di is zero and saturated
// just below 256 where d0 >= 4*di; the ratios are normalized by their sum with
// round-to-nearest, weights one to three below removal_threshold are dropped and
// the rest renormalized. A zero ratio sum (d0 <= 0) gives (1,0,0,0). The block
// takes one request per clock unless stalled; its pipeline is an 18-stage
// ratio divider plus two multiply stages per lane, a sum stage, two 17-stage
// normalizing dividers with a threshold stage between them, and the output
// register. The whole pipeline advances together; it stalls only while a
// finished result sits in the output register and m_tready is low.
// removal_threshold resets to 655 (about 0.01) and is written through cfg_we;
// write it only while no request is in flight.
module inverse_distance_weight_four
    import idw_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // config
    input  wire logic                   cfg_we,
    input  wire logic [WGT_W-1:0]       cfg_wdata,
    // request in
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // dist_0, dist_1, dist_2, dist_3
    // result out
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata    // weight_0 .. weight_3, zero pad
);
    logic                 en;
    logic [WGT_W-1:0]     thresh_reg;
    logic [DMAG_W-1:0]    dmag [4];
    logic [R_W-1:0]       ratio [4];
    logic                 lane_valid [4];

    logic [R_W-1:0]       r_reg [4];
    logic [SUM_W-1:0]     sum_reg;
    logic                 sv_reg;

    logic [WGT_W-1:0]     n1_q [4];
    logic                 n1_valid;
    logic                 n1_zero;

    logic [WGT_W-1:0]     wt_next [4];
    logic [WGT_W-1:0]     wt_reg  [4];
    logic [SUM2_W-1:0]    sum2_reg;
    logic                 tv_reg;

    logic [WGT_W-1:0]     n2_q [4];
    logic                 n2_valid;
    logic                 n2_zero;

    logic [WGT_W-1:0]     out_reg [4];
    logic                 out_valid_reg;

    // Pipeline moves whenever the output slot is free or being drained.
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= THRESH_RESET;
        end
        else if (cfg_we)
        begin
            thresh_reg <= cfg_wdata;
        end
    end

    // Clamp negatives to zero and run the ratio lanes.
    for (genvar i = 0; i < 4; i++) begin : g_lane
        assign dmag[i] = s_tdata[DIST_W*i+DIST_W-1] ? '0 : s_tdata[DIST_W*i +: DMAG_W];

        idw_ratio u_ratio (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (s_tvalid),
            .d0        (dmag[0]),
            .di        (dmag[i]),
            .out_valid (lane_valid[i]),
            .ratio     (ratio[i])
        );
    end

    // Merge: ratio sum.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                r_reg[i] <= ratio[i];
            end
            sum_reg <= SUM_W'(ratio[0]) + SUM_W'(ratio[1])
                     + SUM_W'(ratio[2]) + SUM_W'(ratio[3]);
        end
    end

    // First normalization; numerator carries the half-sum for rounding.
    // The zero-sum flag rides along with lane 0.
    for (genvar i = 0; i < 4; i++) begin : g_norm1
        if (i == 0) begin : g_with_flag
            idw_div #(.DEN_W(SUM_W), .QUO_W(WGT_W), .SIDE_W(1)) u_div (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .in_valid  (sv_reg),
                .num       ({3'b000, r_reg[i], {W_FRAC{1'b0}}}
                            + (SUM_W+WGT_W)'(sum_reg[SUM_W-1:1])),
                .den       (sum_reg),
                .side_in   (sum_reg == '0),
                .out_valid (n1_valid),
                .quo       (n1_q[i]),
                .side_out  (n1_zero)
            );
        end else begin : g_plain
            idw_div #(.DEN_W(SUM_W), .QUO_W(WGT_W), .SIDE_W(1)) u_div (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .in_valid  (sv_reg),
                .num       ({3'b000, r_reg[i], {W_FRAC{1'b0}}}
                            + (SUM_W+WGT_W)'(sum_reg[SUM_W-1:1])),
                .den       (sum_reg),
                .side_in   (1'b0),
                .out_valid (),
                .quo       (n1_q[i]),
                .side_out  ()
            );
        end
    end

    // Threshold removal; a zero sum forces (1,0,0,0), which renormalizes to itself.
    always_comb
    begin
        wt_next[0] = n1_zero ? ONE_W : n1_q[0];
        for (int i = 1; i < 4; i++)
        begin
            wt_next[i] = (n1_zero || (n1_q[i] < thresh_reg)) ? '0 : n1_q[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                wt_reg[i] <= wt_next[i];
            end
            sum2_reg <= SUM2_W'(wt_next[0]) + SUM2_W'(wt_next[1])
                      + SUM2_W'(wt_next[2]) + SUM2_W'(wt_next[3]);
        end
    end

    // Renormalization over the surviving weights.
    for (genvar i = 0; i < 4; i++) begin : g_norm2
        if (i == 0) begin : g_with_flag
            idw_div #(.DEN_W(SUM2_W), .QUO_W(WGT_W), .SIDE_W(1)) u_div (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .in_valid  (tv_reg),
                .num       ({3'b000, wt_reg[i], {W_FRAC{1'b0}}}
                            + (SUM2_W+WGT_W)'(sum2_reg[SUM2_W-1:1])),
                .den       (sum2_reg),
                .side_in   (sum2_reg == '0),
                .out_valid (n2_valid),
                .quo       (n2_q[i]),
                .side_out  (n2_zero)
            );
        end else begin : g_plain
            idw_div #(.DEN_W(SUM2_W), .QUO_W(WGT_W), .SIDE_W(1)) u_div (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .in_valid  (tv_reg),
                .num       ({3'b000, wt_reg[i], {W_FRAC{1'b0}}}
                            + (SUM2_W+WGT_W)'(sum2_reg[SUM2_W-1:1])),
                .den       (sum2_reg),
                .side_in   (1'b0),
                .out_valid (),
                .quo       (n2_q[i]),
                .side_out  ()
            );
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv_reg        <= 1'b0;
            tv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            sv_reg        <= lane_valid[0];
            tv_reg        <= n1_valid;
            out_valid_reg <= n2_valid;
        end
    end

    // All weights gone after removal: they stay zero.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                out_reg[i] <= n2_zero ? '0 : n2_q[i];
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_TDATA_W - 4*WGT_W)'(0),
                       out_reg[3], out_reg[2], out_reg[1], out_reg[0]};
endmodule
`default_nettype wire

>>> hdl/idw_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module idw_div
    import idw_pkg::*;
#(
    parameter int DEN_W  = 23,
    parameter int QUO_W  = 18,
    parameter int SIDE_W = 1
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    en,
    input  wire logic                    in_valid,
    input  wire logic [DEN_W+QUO_W-1:0]  num,
    input  wire logic [DEN_W-1:0]        den,
    input  wire logic [SIDE_W-1:0]       side_in,
    output logic                         out_valid,
    output logic [QUO_W-1:0]             quo,
    output logic [SIDE_W-1:0]            side_out
);
    localparam int NUM_W = DEN_W + QUO_W;

    logic [DEN_W-1:0]  rem_reg  [QUO_W];
    logic [DEN_W-1:0]  den_reg  [QUO_W];
    logic [QUO_W-1:0]  low_reg  [QUO_W];
    logic [QUO_W-1:0]  quo_reg  [QUO_W];
    logic [SIDE_W-1:0] side_reg [QUO_W];
    logic              vld_reg  [QUO_W];

    for (genvar s = 0; s < QUO_W; s++) begin : g_stage
        logic [DEN_W-1:0]  rem_i;
        logic [DEN_W-1:0]  den_i;
        logic [QUO_W-1:0]  low_i;
        logic [QUO_W-1:0]  quo_i;
        logic [SIDE_W-1:0] side_i;
        logic              vld_i;
        logic [DEN_W:0]    trial;
        logic [DEN_W:0]    diff;
        logic              ge;

        if (s == 0) begin : g_first
            assign rem_i  = num[NUM_W-1:QUO_W];
            assign den_i  = den;
            assign low_i  = num[QUO_W-1:0];
            assign quo_i  = '0;
            assign side_i = side_in;
            assign vld_i  = in_valid;
        end else begin : g_next
            assign rem_i  = rem_reg[s-1];
            assign den_i  = den_reg[s-1];
            assign low_i  = low_reg[s-1];
            assign quo_i  = quo_reg[s-1];
            assign side_i = side_reg[s-1];
            assign vld_i  = vld_reg[s-1];
        end

        assign trial = {rem_i, low_i[QUO_W-1]};
        assign ge    = trial >= {1'b0, den_i};
        assign diff  = trial - {1'b0, den_i};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[s] <= vld_i;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                den_reg[s]  <= den_i;
                low_reg[s]  <= {low_i[QUO_W-2:0], 1'b0};
                quo_reg[s]  <= {quo_i[QUO_W-2:0], ge};
                side_reg[s] <= side_i;
            end
        end
    end

    assign out_valid = vld_reg[QUO_W-1];
    assign quo       = quo_reg[QUO_W-1];
    assign side_out  = side_reg[QUO_W-1];
endmodule
`default_nettype wire

>>> hdl/idw_ratio.sv
// One ratio lane: (d0/di)^4 via pipelined divide and two squarings.
`default_nettype none
module idw_ratio
    import idw_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [DMAG_W-1:0] d0,
    input  wire logic [DMAG_W-1:0] di,
    output logic                   out_valid,
    output logic [R_W-1:0]         ratio
);
    ratio_flags_t          flags_in;
    ratio_flags_t          div_flags;
    logic                  div_valid;
    logic [Q_W-1:0]        q;
    logic [2*Q_W-1:0]      q_sq;
    logic [2*Q2_W-1:0]     q2_sq;
    logic [Q2_W-1:0]       q2_reg;
    ratio_flags_t          f1_reg;
    logic                  v1_reg;
    logic [R_W-1:0]        r_reg;
    logic                  v2_reg;

    assign flags_in.zero = (di == '0);
    assign flags_in.sat  = {2'b00, d0} >= {di, 2'b00};

    idw_div #(.DEN_W(DMAG_W), .QUO_W(Q_W), .SIDE_W($bits(ratio_flags_t))) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .num       ({2'b00, d0, {W_FRAC{1'b0}}}),
        .den       (di),
        .side_in   (flags_in),
        .out_valid (div_valid),
        .quo       (q),
        .side_out  (div_flags)
    );

    assign q_sq  = q * q;
    assign q2_sq = q2_reg * q2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= div_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q2_reg <= q_sq[2*Q_W-1:W_FRAC];
            f1_reg <= div_flags;
            if (f1_reg.zero)
            begin
                r_reg <= '0;
            end
            else if (f1_reg.sat)
            begin
                r_reg <= RATIO_MAX;
            end
            else
            begin
                r_reg <= q2_sq[2*Q2_W-1:W_FRAC];
            end
        end
    end

    assign out_valid = v2_reg;
    assign ratio     = r_reg;
endmodule
`default_nettype wire

>>> tb/sv/tb.sv
// Testbench for inverse_distance_weight_four: queued driver, monitor and scoreboard.
`timescale 1ns / 1ps
module tb;
    import idw_pkg::*;

    typedef struct packed {
        logic [DIST_W-1:0] d3, d2, d1, d0;
    } dist_req_t;

    typedef logic [4*WGT_W-1:0] weight_set_t;   // w3 .. w0

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [WGT_W-1:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    inverse_distance_weight_four dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    dist_req_t   pending_reqs[$];
    weight_set_t expected_weights[$];
    logic [WGT_W-1:0] thresh_model = THRESH_RESET;
    int  mismatches = 0;
    int  in_gap = 0;
    int  out_gap = 0;
    bit  no_idle = 1'b0;
    bit  hold_off = 1'b0;
    bit  in_wait = 1'b0;

    // (d0/di)^4 in Q.16, saturated just below 256
    function automatic logic [63:0] ratio_fourth(logic [63:0] d0, logic [63:0] di);
        logic [63:0] q, q2, r;
        if (di == 0)
            return 0;
        if (d0 >= 4 * di)
            return (64'd256 << W_FRAC) - 1;
        q  = (d0 << W_FRAC) / di;
        q2 = (q * q) >> W_FRAC;
        r  = (q2 * q2) >> W_FRAC;
        return (r > (64'd256 << W_FRAC) - 1) ? (64'd256 << W_FRAC) - 1 : r;
    endfunction

    function automatic weight_set_t idw_weights(dist_req_t rq, logic [WGT_W-1:0] thr);
        logic [63:0] d[4];
        logic [63:0] w[4];
        logic [63:0] s;
        weight_set_t res;
        d[0] = rq.d0[DIST_W-1] ? 0 : 64'(rq.d0);
        d[1] = rq.d1[DIST_W-1] ? 0 : 64'(rq.d1);
        d[2] = rq.d2[DIST_W-1] ? 0 : 64'(rq.d2);
        d[3] = rq.d3[DIST_W-1] ? 0 : 64'(rq.d3);
        for (int i = 0; i < 4; i++)
            w[i] = ratio_fourth(d[0], d[i]);
        s = w[0] + w[1] + w[2] + w[3];
        if (s == 0)
        begin
            w[0] = 64'(ONE_W);
            w[1] = 0; w[2] = 0; w[3] = 0;
        end
        else
        begin
            for (int i = 0; i < 4; i++)
                w[i] = ((w[i] << W_FRAC) + s / 2) / s;
            for (int i = 1; i < 4; i++)
                if (w[i] < 64'(thr))
                    w[i] = 0;
            // renormalize survivors; all-zero leaves them as they are
            s = w[0] + w[1] + w[2] + w[3];
            if (s != 0)
                for (int i = 0; i < 4; i++)
                    w[i] = ((w[i] << W_FRAC) + s / 2) / s;
        end
        for (int i = 0; i < 4; i++)
            res[i*WGT_W +: WGT_W] = w[i][WGT_W-1:0];
        return res;
    endfunction

    // driver: holds the head request until accepted, random gaps between
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_gap > 0)
                in_gap <= in_gap - 1;
            if (in_wait)
                s_tvalid <= 1'b1;   // request still waiting, keep it
            else if (in_gap > 0 || hold_off || pending_reqs.size() == 0)
                s_tvalid <= 1'b0;
            else if (!no_idle && $urandom_range(0, 7) == 0)
            begin
                s_tvalid <= 1'b0;
                in_gap <= $urandom_range(0, 3);
            end
            else
            begin
                s_tvalid <= 1'b1;
                s_tdata <= pending_reqs[0];
            end
            if (out_gap > 0)
            begin
                out_gap <= out_gap - 1;
                m_tready <= 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 7) == 0)
            begin
                out_gap <= $urandom_range(0, 3);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // predictor runs at acceptance, using the current threshold
    always @(posedge clk)
    begin
        in_wait = rst_n && s_tvalid && !s_tready;
        if (rst_n && s_tvalid && s_tready)
        begin
            expected_weights.push_back(idw_weights(dist_req_t'(s_tdata), thresh_model));
            void'(pending_reqs.pop_front());
        end
    end

    // monitor
    always @(posedge clk)
    begin
        weight_set_t exp_w;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_weights.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", m_tdata);
            end
            else
            begin
                exp_w = expected_weights.pop_front();
                for (int i = 0; i < 4; i++)
                    if (m_tdata[i*WGT_W +: WGT_W] !== exp_w[i*WGT_W +: WGT_W])
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("weight_%0d: expected %0d got %0d", i,
                                     exp_w[i*WGT_W +: WGT_W], m_tdata[i*WGT_W +: WGT_W]);
                    end
            end
        end
    end

    function automatic logic [DIST_W-1:0] rand_dist();
        logic [DIST_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = DIST_W'($urandom);                          // any, often negative
            2: v = {1'b0, {(DIST_W-1){1'b1}}};
            3: v = DIST_W'($urandom_range(1, 16));
            default: v = DIST_W'($urandom_range(1, 24'h7FFFFF));
        endcase
        return v;
    endfunction

    // near-equal distances keep all four weights alive at the lower thresholds
    function automatic dist_req_t rand_req();
        dist_req_t rq;
        logic [DIST_W-1:0] base;
        if ($urandom_range(0, 2) != 0)
        begin
            base = DIST_W'($urandom_range(1, 24'h3FFFFF));
            rq.d0 = base;
            rq.d1 = base + DIST_W'($urandom_range(0, 32'(base)));
            rq.d2 = base + DIST_W'($urandom_range(0, 32'(base)));
            rq.d3 = base + DIST_W'($urandom_range(0, 32'(base)));
            if ($urandom_range(0, 9) == 0)
                rq.d3 = rand_dist();
        end
        else
        begin
            rq.d0 = rand_dist(); rq.d1 = rand_dist();
            rq.d2 = rand_dist(); rq.d3 = rand_dist();
        end
        return rq;
    endfunction

    task automatic drain();
        wait (pending_reqs.size() == 0 && expected_weights.size() == 0);
        repeat (70) @(posedge clk);
    endtask

    task automatic write_thresh(logic [WGT_W-1:0] v);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_wdata = v;
        @(negedge clk);
        cfg_we = 1'b0;
        thresh_model = v;
    endtask

    initial
    begin
        logic [WGT_W-1:0] thr_list[5];
        dist_req_t rq;
        thr_list = '{17'd0, 17'd655, 17'd8000, 17'd20000, 17'h1FFFF};
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, clamping, zero sum, saturation, exact ties
        pending_reqs.push_back('{d3: 24'd100, d2: 24'd100, d1: 24'd100, d0: 24'd100});
        pending_reqs.push_back('{d3: 24'd5, d2: 24'd5, d1: 24'd5, d0: 24'd0});
        pending_reqs.push_back('{d3: 24'h800000, d2: 24'hFFFFFF, d1: 24'h7FFFFF,
                                 d0: 24'h800000});
        pending_reqs.push_back('{d3: 24'h7FFFFF, d2: 24'h7FFFFF, d1: 24'h7FFFFF,
                                 d0: 24'h7FFFFF});
        pending_reqs.push_back('{d3: 24'd1, d2: 24'd1, d1: 24'd1, d0: 24'h7FFFFF});
        pending_reqs.push_back('{d3: 24'd0, d2: 24'd0, d1: 24'd0, d0: 24'd7});
        pending_reqs.push_back('{d3: 24'hFFFFFF, d2: 24'd40, d1: 24'd10, d0: 24'd10});
        pending_reqs.push_back('{d3: 24'd40, d2: 24'd39, d1: 24'd41, d0: 24'd10});
        pending_reqs.push_back('{d3: 24'd1000, d2: 24'd300, d1: 24'd120, d0: 24'd100});
        pending_reqs.push_back('{d3: 24'h555555, d2: 24'h2AAAAA, d1: 24'h400000,
                                 d0: 24'h3FFFFF});
        pending_reqs.push_back('{d3: 24'd3, d2: 24'd2, d1: 24'd1, d0: 24'd1});
        pending_reqs.push_back('{d3: 24'd700, d2: 24'd500, d1: 24'd300, d0: 24'h800001});
        drain();

        // random phases across threshold settings, extremes included
        for (int ph = 0; ph < 5; ph++)
        begin
            write_thresh(thr_list[ph]);
            if (ph == 4)
                no_idle = 1'b1;
            for (int n = 0; n < 240; n++)
            begin
                pending_reqs.push_back(rand_req());
                if (ph == 1 && n == 120)
                begin
                    // sender holds off until the pipe is empty
                    wait (pending_reqs.size() == 0);
                    hold_off = 1'b1;
                    wait (expected_weights.size() == 0);
                    hold_off = 1'b0;
                end
            end
            drain();
        end

        if (mismatches == 0)
            $display("[inverse_distance_weight_four] OK");
        else
            $display("[inverse_distance_weight_four] ERROR");
        $finish;
    end

    initial
    begin
        #400000;
        $display("[inverse_distance_weight_four] ERROR");
        $finish;
    end
endmodule
